@@ rtl/akh_pkg.sv @@
// ----------------------------------------------------------------------------
// akh_pkg
// Shared types, constants and register map of the analog key scanner.
// ----------------------------------------------------------------------------
package akh_pkg;

    localparam int KEY_COUNT        = 6;
    localparam int LEVEL_BITS       = 16;
    localparam int LEVEL_FIELD_BITS = 16;
    localparam int KEY_SLOTS        = 6;
    localparam int MASK_BITS        = 6;
    localparam int CODE_BITS        = 8;
    localparam int COUNT_BITS       = 16;
    localparam int SLOT_BITS        = $clog2(KEY_SLOTS + 1);

    localparam int APB_ADDR_BITS = 5;
    localparam int APB_DATA_BITS = 64;
    localparam int REG_IDX_BITS  = 2;

    localparam int Q_DEPTH     = 2;
    localparam int Q_PTR_BITS  = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_CNT_BITS  = $clog2(Q_DEPTH + 1);

    localparam logic [REG_IDX_BITS-1:0] REG_PRESS_DELTA   = 2'd0;
    localparam logic [REG_IDX_BITS-1:0] REG_RELEASE_DELTA = 2'd1;
    localparam logic [REG_IDX_BITS-1:0] REG_SETTLE_FRAMES = 2'd2;
    localparam logic [REG_IDX_BITS-1:0] REG_KEY_CODE_MAP  = 2'd3;

    localparam logic [7:0] KEYCODE_Z = 8'h1D;
    localparam logic [7:0] KEYCODE_X = 8'h1B;
    localparam logic [7:0] KEYCODE_C = 8'h06;
    localparam logic [7:0] KEYCODE_V = 8'h19;
    localparam logic [7:0] KEYCODE_B = 8'h05;
    localparam logic [7:0] KEYCODE_N = 8'h11;

    localparam logic [15:0] PRESS_DELTA_RESET   = 16'd200;
    localparam logic [15:0] RELEASE_DELTA_RESET = 16'd100;
    localparam logic [7:0]  SETTLE_FRAMES_RESET = 8'd8;
    localparam logic [47:0] KEY_CODE_MAP_RESET  =
        {KEYCODE_N, KEYCODE_B, KEYCODE_V, KEYCODE_C, KEYCODE_X, KEYCODE_Z};

    typedef enum logic [2:0] {
        KIND_FRAME   = 3'd0,
        KIND_PEER    = 3'd1,
        KIND_RECAL   = 3'd2,
        KIND_ENABLE  = 3'd3,
        KIND_DISABLE = 3'd4
    } kind_t;

    typedef struct packed {
        logic [15:0] press_delta;
        logic [15:0] release_delta;
        logic [7:0]  settle_frames;
        logic [47:0] key_code_map;
    } cfg_t;

    typedef struct packed {
        logic [MASK_BITS-1:0]  bits;
        logic [MASK_BITS-1:0]  own;
        logic [MASK_BITS-1:0]  peer;
        logic [COUNT_BITS-1:0] count;
    } report_t;

endpackage

@@ rtl/akh_in_if.sv @@
// ----------------------------------------------------------------------------
// akh_in_if
// Request channel into the scanner: frames, peer updates and events.
// ----------------------------------------------------------------------------
interface akh_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [15:0] level_0;
    logic [15:0] level_1;
    logic [15:0] level_2;
    logic [15:0] level_3;
    logic [15:0] level_4;
    logic [15:0] level_5;
    logic        peer_active;
    logic        host_ready;

    modport source (
        output valid, kind, level_0, level_1, level_2, level_3, level_4, level_5,
               peer_active, host_ready,
        input  ready
    );

    modport sink (
        input  valid, kind, level_0, level_1, level_2, level_3, level_4, level_5,
               peer_active, host_ready,
        output ready
    );
endinterface

@@ rtl/akh_out_if.sv @@
// ----------------------------------------------------------------------------
// akh_out_if
// Report channel out of the scanner.
// ----------------------------------------------------------------------------
interface akh_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  code_0;
    logic [7:0]  code_1;
    logic [7:0]  code_2;
    logic [7:0]  code_3;
    logic [7:0]  code_4;
    logic [7:0]  code_5;
    logic [5:0]  pressed_mask;
    logic [5:0]  own_mask;
    logic [5:0]  peer_mask;
    logic [15:0] report_count;

    modport source (
        output valid, code_0, code_1, code_2, code_3, code_4, code_5,
               pressed_mask, own_mask, peer_mask, report_count,
        input  ready
    );

    modport sink (
        input  valid, code_0, code_1, code_2, code_3, code_4, code_5,
               pressed_mask, own_mask, peer_mask, report_count,
        output ready
    );
endinterface

@@ rtl/analog_key_hysteresis_scanner.sv @@
// ----------------------------------------------------------------------------
// analog_key_hysteresis_scanner
// Six-key analog scanner with settle, baseline, press/release hysteresis,
// peer mask merging and change reports.
// ----------------------------------------------------------------------------
// A report passes from the front through the report queue and then the output
// register; the front updates all key state in the accepting cycle.
// Throughput: one request per cycle while the report queue is not full.
// A two-entry report queue lets the front keep going while the host stalls.
// Reset: rst_n clears all control state and loads register defaults at once;
// the baseline store holds no valid data until the first baseline frame.
module analog_key_hysteresis_scanner
    import akh_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [APB_ADDR_BITS-1:0] paddr,
    input  logic [APB_DATA_BITS-1:0] pwdata,
    output logic [APB_DATA_BITS-1:0] prdata,
    output logic                     pready,
    akh_in_if.sink                   in_ch,
    akh_out_if.source                out_ch
);

    cfg_t    cfg;
    logic    q_push;
    logic    q_pop;
    logic    q_full;
    logic    q_empty;
    report_t q_in;
    report_t q_out;

    akh_apb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    akh_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .in_ch  (in_ch),
        .q_full (q_full),
        .q_push (q_push),
        .q_data (q_in)
    );

    akh_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .pop       (q_pop),
        .pop_data  (q_out),
        .full      (q_full),
        .empty     (q_empty)
    );

    akh_report u_report (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .q_empty (q_empty),
        .q_data  (q_out),
        .q_pop   (q_pop),
        .out_ch  (out_ch)
    );

endmodule

@@ rtl/akh_apb_regs.sv @@
// ----------------------------------------------------------------------------
// akh_apb_regs
// APB configuration registers: thresholds, settle count and keycode map.
// ----------------------------------------------------------------------------
module akh_apb_regs
    import akh_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [APB_ADDR_BITS-1:0] paddr,
    input  logic [APB_DATA_BITS-1:0] pwdata,
    output logic [APB_DATA_BITS-1:0] prdata,
    output logic                     pready,
    output cfg_t                     cfg
);

    logic [15:0]             press_delta_reg;
    logic [15:0]             release_delta_reg;
    logic [7:0]              settle_frames_reg;
    logic [47:0]             key_code_map_reg;
    logic [REG_IDX_BITS-1:0] reg_idx;
    logic                    wr_en;

    assign reg_idx = paddr[APB_ADDR_BITS-1:3];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            press_delta_reg   <= PRESS_DELTA_RESET;
            release_delta_reg <= RELEASE_DELTA_RESET;
            settle_frames_reg <= SETTLE_FRAMES_RESET;
            key_code_map_reg  <= KEY_CODE_MAP_RESET;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_PRESS_DELTA:   press_delta_reg   <= pwdata[15:0];
                REG_RELEASE_DELTA: release_delta_reg <= pwdata[15:0];
                REG_SETTLE_FRAMES: settle_frames_reg <= pwdata[7:0];
                REG_KEY_CODE_MAP:  key_code_map_reg  <= pwdata[47:0];
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_PRESS_DELTA:   prdata = APB_DATA_BITS'(press_delta_reg);
            REG_RELEASE_DELTA: prdata = APB_DATA_BITS'(release_delta_reg);
            REG_SETTLE_FRAMES: prdata = APB_DATA_BITS'(settle_frames_reg);
            REG_KEY_CODE_MAP:  prdata = APB_DATA_BITS'(key_code_map_reg);
            default:           prdata = '0;
        endcase
    end

    assign cfg.press_delta   = press_delta_reg;
    assign cfg.release_delta = release_delta_reg;
    assign cfg.settle_frames = settle_frames_reg;
    assign cfg.key_code_map  = key_code_map_reg;

endmodule

@@ rtl/akh_front.sv @@
// ----------------------------------------------------------------------------
// akh_front
// Accepts requests, runs settle, baseline and hysteresis per key, merges the
// peer mask and decides whether a report is due.
// ----------------------------------------------------------------------------
module akh_front
    import akh_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  cfg_t      cfg,
    akh_in_if.sink    in_ch,
    input  logic      q_full,
    output logic      q_push,
    output report_t   q_data
);

    logic                  enabled_reg, enabled_next;
    logic                  taken_reg, taken_next;
    logic [7:0]            settle_reg, settle_next;
    logic [MASK_BITS-1:0]  held_reg, held_next;
    logic [MASK_BITS-1:0]  peer_over_reg, peer_over_next;
    logic [MASK_BITS-1:0]  last_reg, last_next;
    logic [COUNT_BITS-1:0] count_reg, count_next;
    logic [LEVEL_BITS-1:0] base_reg [KEY_COUNT];
    logic                  base_load;
    logic [LEVEL_FIELD_BITS-1:0] lv_in [KEY_SLOTS];
    logic                  accept;
    kind_t                 kind;

    assign in_ch.ready = !q_full;
    assign accept      = in_ch.valid && !q_full;
    assign kind        = kind_t'(in_ch.kind);

    assign lv_in[0] = in_ch.level_0;
    assign lv_in[1] = in_ch.level_1;
    assign lv_in[2] = in_ch.level_2;
    assign lv_in[3] = in_ch.level_3;
    assign lv_in[4] = in_ch.level_4;
    assign lv_in[5] = in_ch.level_5;

    always_comb
    begin
        logic [LEVEL_BITS-1:0] lvl;
        logic [LEVEL_BITS-1:0] gap;
        logic [MASK_BITS-1:0]  own;
        logic [MASK_BITS-1:0]  peer;
        logic [MASK_BITS-1:0]  merged;
        logic [MASK_BITS-1:0]  over;
        logic [15:0]           thr;
        logic                  now;

        enabled_next   = enabled_reg;
        taken_next     = taken_reg;
        settle_next    = settle_reg;
        held_next      = held_reg;
        peer_over_next = peer_over_reg;
        last_next      = last_reg;
        count_next     = count_reg;
        base_load      = 1'b0;
        q_push         = 1'b0;
        q_data         = '0;
        own            = '0;
        over           = '0;
        thr            = cfg.press_delta >> 3;

        for (int k = 0; k < KEY_COUNT; k++)
        begin
            lvl  = lv_in[k][LEVEL_BITS-1:0];
            gap  = (lvl >= base_reg[k]) ? (lvl - base_reg[k]) : (base_reg[k] - lvl);
            now  = held_reg[k] ? (16'(gap) > cfg.release_delta)
                               : (16'(gap) > cfg.press_delta);
            own[k]  = now;
            over[k] = lv_in[k] > thr;
        end

        peer   = in_ch.peer_active ? peer_over_reg : '0;
        merged = own | peer;

        if (accept)
        begin
            case (kind)
                KIND_FRAME:
                begin
                    if (settle_reg != 8'd0)
                    begin
                        settle_next = settle_reg - 8'd1;
                    end
                    else if (!taken_reg)
                    begin
                        base_load  = 1'b1;
                        taken_next = 1'b1;
                    end
                    else
                    begin
                        held_next = own;
                        if (enabled_reg && (merged != last_reg) && in_ch.host_ready)
                        begin
                            last_next    = merged;
                            count_next   = count_reg + 16'd1;
                            q_push       = 1'b1;
                            q_data.bits  = merged;
                            q_data.own   = own;
                            q_data.peer  = peer;
                            q_data.count = count_reg + 16'd1;
                        end
                    end
                end
                KIND_PEER:
                begin
                    peer_over_next = over;
                end
                KIND_RECAL:
                begin
                    taken_next  = 1'b0;
                    settle_next = cfg.settle_frames;
                end
                KIND_ENABLE:
                begin
                    enabled_next = 1'b1;
                end
                KIND_DISABLE:
                begin
                    enabled_next = 1'b0;
                    if (last_reg != '0)
                    begin
                        last_next = '0;
                        if (in_ch.host_ready)
                        begin
                            q_push       = 1'b1;
                            q_data.bits  = '0;
                            q_data.own   = held_reg;
                            q_data.peer  = '0;
                            q_data.count = count_reg;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enabled_reg   <= 1'b0;
            taken_reg     <= 1'b0;
            settle_reg    <= SETTLE_FRAMES_RESET;
            held_reg      <= '0;
            peer_over_reg <= '0;
            last_reg      <= '0;
            count_reg     <= '0;
        end
        else
        begin
            enabled_reg   <= enabled_next;
            taken_reg     <= taken_next;
            settle_reg    <= settle_next;
            held_reg      <= held_next;
            peer_over_reg <= peer_over_next;
            last_reg      <= last_next;
            count_reg     <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (base_load)
        begin
            for (int k = 0; k < KEY_COUNT; k++)
            begin
                base_reg[k] <= lv_in[k][LEVEL_BITS-1:0];
            end
        end
    end

endmodule

@@ rtl/akh_queue.sv @@
// ----------------------------------------------------------------------------
// akh_queue
// Short report queue between the scan front and the report formatter.
// ----------------------------------------------------------------------------
module akh_queue
    import akh_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  report_t push_data,
    input  logic    pop,
    output report_t pop_data,
    output logic    full,
    output logic    empty
);

    report_t               mem_reg [Q_DEPTH];
    logic [Q_PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [Q_CNT_BITS-1:0] cnt_reg, cnt_next;

    assign full     = (cnt_reg == Q_CNT_BITS'(Q_DEPTH));
    assign empty    = (cnt_reg == '0);
    assign pop_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == Q_PTR_BITS'(Q_DEPTH - 1)) ? '0
                                                                   : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == Q_PTR_BITS'(Q_DEPTH - 1)) ? '0
                                                                   : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (!full || pop))
        else $error("report queue written while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("report queue read while empty");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (cnt_reg == $past(cnt_reg) + 1'b1))
        else $error("report queue fill count did not advance");

endmodule

@@ rtl/akh_report.sv @@
// ----------------------------------------------------------------------------
// akh_report
// Turns a queued key mask into a packed list of keycodes and holds it in the
// output register until the host side takes it.
// ----------------------------------------------------------------------------
module akh_report
    import akh_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  cfg_t      cfg,
    input  logic      q_empty,
    input  report_t   q_data,
    output logic      q_pop,
    akh_out_if.source out_ch
);

    logic                 valid_reg;
    logic [CODE_BITS-1:0] codes_reg [KEY_SLOTS];
    logic [CODE_BITS-1:0] codes_next [KEY_SLOTS];
    report_t              rep_reg;

    assign q_pop = !q_empty && (!valid_reg || out_ch.ready);

    always_comb
    begin
        logic [SLOT_BITS-1:0] slot;
        slot = '0;
        for (int n = 0; n < KEY_SLOTS; n++)
        begin
            codes_next[n] = '0;
        end
        for (int k = 0; k < KEY_COUNT; k++)
        begin
            if (q_data.bits[k] && (slot < SLOT_BITS'(KEY_SLOTS)))
            begin
                codes_next[slot] = cfg.key_code_map[CODE_BITS*k +: CODE_BITS];
                slot = slot + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (q_pop)
        begin
            valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            rep_reg <= q_data;
            for (int n = 0; n < KEY_SLOTS; n++)
            begin
                codes_reg[n] <= codes_next[n];
            end
        end
    end

    assign out_ch.valid        = valid_reg;
    assign out_ch.code_0       = codes_reg[0];
    assign out_ch.code_1       = codes_reg[1];
    assign out_ch.code_2       = codes_reg[2];
    assign out_ch.code_3       = codes_reg[3];
    assign out_ch.code_4       = codes_reg[4];
    assign out_ch.code_5       = codes_reg[5];
    assign out_ch.pressed_mask = rep_reg.bits;
    assign out_ch.own_mask     = rep_reg.own;
    assign out_ch.peer_mask    = rep_reg.peer;
    assign out_ch.report_count = rep_reg.count;

    a_empty_report_codes: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && (rep_reg.bits == '0)) |->
            ((codes_reg[0] == '0) && (codes_reg[5] == '0) && (rep_reg.peer == '0)))
        else $error("empty report carries keycodes");

endmodule
